### rtl/c3f_pkg.sv
// c3f_pkg: shared types and constants for the 3x3 convolution filter.
// No dependencies.
package c3f_pkg;

  localparam int PIX_W = 8;
  localparam int POS_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KTOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KMID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KBOT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd5;

  // one classified request handed from the front end to the back end
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] win;   // [row][col], col 2 newest
    logic [PIX_W-1:0]           pix;   // incoming pixel
    logic [POS_W-1:0]           col;
    logic [POS_W-1:0]           row;
    logic                       em_a;  // pixel (c-1, r-1)
    logic                       filt_a;// that pixel is interior
    logic                       em_b;  // pixel (c, r-1), last column
    logic                       em_c;  // pixel (c, r), last row
    logic                       done_c;
  } c3f_req_t;

  // one result item
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_done;
    logic             run_last;
  } c3f_res_t;

endpackage

### rtl/c3f_ram.sv
// c3f_ram: generic single-port-write / single-read RAM with registered read.
// No dependencies.
module c3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/c3f_front.sv
// c3f_front: accepts pixels, tracks position, reads line stores, shifts the
// window and classifies each pixel into a back-end request. Uses c3f_pkg, c3f_ram.
module c3f_front
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pix,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,   // clamped
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,  // clamped
  output logic                 req_valid,
  input  logic                 req_ready,
  output c3f_req_t             req
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT+1);

  // stage 0: position; stage 1: RAM read in flight
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          s1_vld_r;
  logic [AW-1:0] s1_col_r;
  logic [CW-1:0] s1_c_r;
  logic [RW-1:0] s1_r_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] old_q, new_q;
  logic [2:0][2:0][PIX_W-1:0] win_r, win_nxt;
  logic          acc, adv;
  logic          bypass_r;
  logic [PIX_W-1:0] byp_old_r, byp_new_r;
  logic [PIX_W-1:0] rd_old, rd_new;

  assign adv = !s1_vld_r || req_ready;
  assign in_ready = adv;
  assign acc = in_valid && in_ready;

  // wrap position in case geometry changed
  always_comb begin
    c_cur = col_r;
    r_cur = row_r;
    if (c_cur >= width) begin
      c_cur = '0;
      r_cur = r_cur + 1'b1;
    end
    if (r_cur >= height) r_cur = '0;
    col_nxt = c_cur + 1'b1;
    row_nxt = r_cur;
    if (col_nxt >= width) begin
      col_nxt = '0;
      row_nxt = r_cur + 1'b1;
      if (row_nxt >= height) row_nxt = '0;
    end
  end

  // same column read right after write (width 1) needs a bypass
  logic same_col;
  assign same_col = s1_vld_r && (s1_col_r == c_cur[AW-1:0]);

  c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(s1_vld_r && req_ready), .waddr(s1_col_r), .wdata(rd_new),
    .re(acc), .raddr(c_cur[AW-1:0]), .rdata(old_q));
  c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(s1_vld_r && req_ready), .waddr(s1_col_r), .wdata(s1_pix_r),
    .re(acc), .raddr(c_cur[AW-1:0]), .rdata(new_q));

  assign rd_old = bypass_r ? byp_old_r : old_q;
  assign rd_new = bypass_r ? byp_new_r : new_q;

  // window after this pixel shifts in
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = rd_old;
    win_nxt[1][2] = rd_new;
    win_nxt[2][2] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_vld_r <= 1'b0;
      win_r <= '0;
    end else begin
      if (s1_vld_r && req_ready) win_r <= win_nxt;
      if (adv) s1_vld_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r <= c_cur[AW-1:0];
      s1_c_r <= c_cur;
      s1_r_r <= r_cur;
      s1_pix_r <= in_pix;
      bypass_r <= same_col;
      byp_old_r <= rd_new;
      byp_new_r <= s1_pix_r;
    end
  end

  // classify
  logic last_col, last_row;
  assign last_col = ({1'b0, s1_c_r} + 1'b1) == {1'b0, width};
  assign last_row = ({1'b0, s1_r_r} + 1'b1) == {1'b0, height};

  always_comb begin
    req_valid = s1_vld_r;
    req.win = win_nxt;
    req.pix = s1_pix_r;
    req.col = POS_W'(s1_c_r);
    req.row = POS_W'(s1_r_r);
    req.em_a = (s1_r_r != '0) && (s1_c_r != '0);
    // (c-1, r-1) is interior once c and r are at least 2
    req.filt_a = (s1_c_r >= CW'(2)) && (s1_r_r >= RW'(2));
    req.em_b = (s1_r_r != '0) && last_col;
    req.em_c = last_row;
    req.done_c = last_col;
  end

endmodule

### rtl/c3f_back.sv
// c3f_back: takes requests from the front end, computes the weighted sum, divides with
// an iterative divider and emits up to three results. Uses c3f_pkg.
module c3f_back
  import c3f_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  c3f_req_t    req,
  input  logic [17:0] k_top,
  input  logic [17:0] k_mid,
  input  logic [17:0] k_bot,
  input  logic [7:0]  divisor,
  output logic        res_valid,
  input  logic        res_ready,
  output c3f_res_t    res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0] st_r, st_nxt;
  c3f_req_t   q_r;
  logic [3:0] tap_r;
  logic [1:0] tr_r, tc_r;   // kernel row and column of the current tap
  logic signed [17:0] sum_r;
  logic [17:0] num_r;   // 2*|sum| + d
  logic [17:0] quo_r;
  logic [8:0]  rem_r;   // remainder vs 2*d
  logic [4:0]  bit_r;
  logic        neg_r;
  logic [8:0]  d2;
  logic [7:0]  d_eff;
  logic [2:0]  pend_r;  // a,b,c still to emit
  c3f_res_t    out_r;
  logic        out_vld_r;

  assign d_eff = (divisor == 8'd0) ? 8'd1 : divisor;
  assign d2 = {d_eff, 1'b0};
  assign req_ready = (st_r == ST_IDLE);

  // one tap per cycle
  logic [17:0] krow;
  logic signed [5:0] wgt;
  logic signed [14:0] prod;
  logic signed [17:0] sum_fin;
  logic [17:0] mag;
  always_comb begin
    case (tr_r)
      2'd0: krow = k_top;
      2'd1: krow = k_mid;
      default: krow = k_bot;
    endcase
    wgt = $signed(krow[tc_r*6 +: 6]);
    prod = $signed({1'b0, q_r.win[tr_r][tc_r]}) * wgt;
    sum_fin = sum_r + 18'(prod);
    mag = sum_fin[17] ? 18'(-sum_fin) : 18'(sum_fin);
  end

  // restoring division step
  logic [9:0] rem_sh;
  assign rem_sh = {rem_r, num_r[17]};

  // saturated quotient
  logic [7:0] sat;
  always_comb begin
    if (neg_r) sat = 8'd0;
    else if (quo_r > 18'd255) sat = 8'd255;
    else sat = quo_r[7:0];
  end

  // next pending result
  logic [2:0] pend_next;
  c3f_res_t   cand;
  always_comb begin
    cand = '0;
    pend_next = pend_r;
    if (pend_r[0]) begin
      cand.pix = q_r.filt_a ? sat : q_r.win[1][1];
      cand.col = q_r.col - 1'b1;
      cand.row = q_r.row - 1'b1;
      pend_next[0] = 1'b0;
    end else if (pend_r[1]) begin
      cand.pix = q_r.win[1][2];
      cand.col = q_r.col;
      cand.row = q_r.row - 1'b1;
      pend_next[1] = 1'b0;
    end else begin
      cand.pix = q_r.pix;
      cand.col = q_r.col;
      cand.row = q_r.row;
      cand.frame_done = q_r.done_c;
      pend_next[2] = 1'b0;
    end
    cand.run_last = (pend_next == 3'd0);
  end

  logic out_free;
  assign out_free = !out_vld_r || res_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (req_valid) begin
        if (req.em_a && req.filt_a) st_nxt = ST_MAC;
        else if (req.em_a || req.em_b || req.em_c) st_nxt = ST_EMIT;
      end
      ST_MAC:  if (tap_r == 4'd8) st_nxt = ST_DIV;
      ST_DIV:  if (bit_r == 5'd17) st_nxt = ST_EMIT;
      ST_EMIT: if (out_free && pend_next == 3'd0) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_vld_r <= 1'b0;
      pend_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (res_ready) out_vld_r <= 1'b0;
      if (st_r == ST_IDLE && req_valid)
        pend_r <= {req.em_c, req.em_b, req.em_a};
      if (st_r == ST_EMIT && out_free) begin
        out_vld_r <= 1'b1;
        pend_r <= pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_EMIT && out_free) out_r <= cand;
    unique case (st_r)
      ST_IDLE: begin
        q_r <= req;
        tap_r <= '0;
        tr_r <= '0;
        tc_r <= '0;
        sum_r <= '0;
      end
      ST_MAC: begin
        sum_r <= sum_fin;
        tap_r <= tap_r + 1'b1;
        if (tc_r == 2'd2) begin
          tc_r <= '0;
          tr_r <= (tr_r == 2'd2) ? 2'd0 : tr_r + 1'b1;
        end else begin
          tc_r <= tc_r + 1'b1;
        end
        if (tap_r == 4'd8) begin
          neg_r <= sum_fin[17];
          num_r <= {mag[16:0], 1'b0} + {10'd0, d_eff};
          rem_r <= '0;
          quo_r <= '0;
          bit_r <= '0;
        end
      end
      // 18 quotient bits, one per cycle
      ST_DIV: begin
        num_r <= {num_r[16:0], 1'b0};
        if (rem_sh >= {1'b0, d2}) begin
          rem_r <= 9'(rem_sh - {1'b0, d2});
          quo_r <= {quo_r[16:0], 1'b1};
        end else begin
          rem_r <= rem_sh[8:0];
          quo_r <= {quo_r[16:0], 1'b0};
        end
        bit_r <= bit_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign res_valid = out_vld_r;
  assign res = out_r;

endmodule

### rtl/conv3x3_image_filter.sv
// conv3x3_image_filter: top level of the 3x3 convolution filter.
// Ring results bypass the arithmetic; an interior result goes through a MAC
// that takes one tap at a time and then an iterative bit-serial divider.
// The input stalls while a request waits in stage 1 and the back end is busy
// with the previous one, including while its results wait on the output.
// Reset (synchronous, rst_n low) clears position, window and registers to
// their defaults; line stores need no clearing pass.
module conv3x3_image_filter
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_pixel, out_col, out_row, frame_done, zeros
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT+1);

  logic [10:0] width_r, height_r;
  logic [17:0] ktop_r, kmid_r, kbot_r;
  logic [7:0]  div_r;
  logic [CW-1:0] w_cl;
  logic [RW-1:0] h_cl;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd640;
      height_r <= 11'd480;
      ktop_r <= '0;
      kmid_r <= 18'd64;
      kbot_r <= '0;
      div_r <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:   width_r <= cfg_data[10:0];
        REG_HEIGHT:  height_r <= cfg_data[10:0];
        REG_KTOP:    ktop_r <= cfg_data;
        REG_KMID:    kmid_r <= cfg_data;
        REG_KBOT:    kbot_r <= cfg_data;
        REG_DIVISOR: div_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // clamp geometry
  always_comb begin
    if (width_r == '0) w_cl = CW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_cl = CW'(MAX_WIDTH);
    else w_cl = CW'(width_r);
    if (height_r == '0) h_cl = RW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_cl = RW'(MAX_HEIGHT);
    else h_cl = RW'(height_r);
  end

  logic     rq_valid, rq_ready;
  c3f_req_t rq;
  logic     rs_valid;
  c3f_res_t rs;

  c3f_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_pix(s_axis_tdata),
    .width(w_cl), .height(h_cl),
    .req_valid(rq_valid), .req_ready(rq_ready), .req(rq));

  c3f_back u_back (
    .clk(clk), .rst_n(rst_n),
    .req_valid(rq_valid), .req_ready(rq_ready), .req(rq),
    .k_top(ktop_r), .k_mid(kmid_r), .k_bot(kbot_r), .divisor(div_r),
    .res_valid(rs_valid), .res_ready(m_axis_tready), .res(rs));

  assign m_axis_tvalid = rs_valid;
  assign m_axis_tdata = {3'd0, rs.frame_done, rs.row, rs.col, rs.pix};
  assign m_axis_tlast = rs.run_last;

  // frame_done only on a last-of-run result
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tlast) else $error("done without last");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(m_axis_tvalid && !m_axis_tready) |-> m_axis_tvalid) else $error("result dropped");

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for conv3x3_image_filter.
// Depends on rtl/c3f_pkg.sv and rtl/conv3x3_image_filter.sv. A built-in
// pixel filter predictor checks every result request field by field.
`timescale 1ns / 100ps

module tb_top;
  import c3f_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  conv3x3_image_filter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),     // pixel_value
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),     // out_pixel, out_col, out_row, frame_done
    .m_axis_tlast  (m_tlast),     // run_last
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // stimulus and expectation stores
  logic [7:0] pending_pixels[$];
  c3f_res_t   expected_results[$];

  int pixels_sent = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int mismatches = 0;
  int want_hold = 0;
  int hold_count = 0;
  int idle_cycles = 0;

  // predictor state
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [17:0] kern_reg[3];
  logic [7:0]  divisor_reg;
  logic [7:0]  older_line[MAXW];
  logic [7:0]  newer_line[MAXW];
  logic [7:0]  win[3][3];
  int          col_cnt;
  int          row_cnt;

  function automatic int clamp_dim(logic [10:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // weighted sum, divide, round half away from zero, saturate
  function automatic logic [7:0] filter_pixel();
    int sum;
    int d;
    int mag;
    int q;
    sum = 0;
    d = (divisor_reg == 0) ? 1 : int'(divisor_reg);
    for (int r = 0; r < 3; r++)
      for (int j = 0; j < 3; j++)
        sum += int'(win[r][j]) * int'($signed(kern_reg[r][6*j +: 6]));
    mag = (sum < 0) ? -sum : sum;
    q = (2 * mag + d) / (2 * d);
    if (sum < 0) q = -q;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic void push_result(logic [7:0] p, int c, int r, bit done);
    c3f_res_t e;
    e.pix = p;
    e.col = c[9:0];
    e.row = r[9:0];
    e.frame_done = done;
    e.run_last = 1'b0;
    expected_results.push_back(e);
  endfunction

  // advance the filter state by one pixel and queue the results it causes
  function automatic void advance_filter(logic [7:0] p);
    int w;
    int h;
    int c;
    int r;
    int n;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    n = 0;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = older_line[c];
    win[1][2] = newer_line[c];
    win[2][2] = p;
    older_line[c] = newer_line[c];
    newer_line[c] = p;
    if (r >= 1 && c >= 1) begin
      if (c - 1 >= 1 && c + 1 <= w && r - 1 >= 1 && r + 1 <= h)
        push_result(filter_pixel(), c - 1, r - 1, 1'b0);
      else
        push_result(win[1][1], c - 1, r - 1, 1'b0);
      n++;
    end
    if (r >= 1 && c + 1 == w) begin
      push_result(win[1][2], c, r - 1, 1'b0);
      n++;
    end
    if (r + 1 == h) begin
      push_result(p, c, r, c + 1 == w);
      n++;
    end
    if (n > 0) expected_results[expected_results.size()-1].run_last = 1'b1;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // idle and stall percentages rotate with progress
  function automatic int sender_idle_pct();
    case ((pixels_sent / 100) % 4)
      1: return 46;
      3: return 26;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((pixels_sent / 100) % 4)
      2: return 46;
      3: return 26;
      default: return 0;
    endcase
  endfunction

  // driver: one pixel request at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pixels_sent++;
      if (!s_tvalid || s_tready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_pixels.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off counter, runs once when requested
  always @(posedge clk) begin
    if (want_hold != 0 && hold_count < HOLD_CYCLES)
      hold_count <= hold_count + 1;
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    c3f_res_t e;
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("MISMATCH: unexpected result, tdata %h", m_tdata);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[7:0] != e.pix) report_mismatch("pixel", m_tdata[7:0], e.pix);
          if (m_tdata[17:8] != e.col) report_mismatch("col", m_tdata[17:8], e.col);
          if (m_tdata[27:18] != e.row) report_mismatch("row", m_tdata[27:18], e.row);
          if (m_tdata[28] != e.frame_done)
            report_mismatch("frame_done", m_tdata[28], e.frame_done);
          if (m_tdata[31:29] != 3'b000) report_mismatch("pad", m_tdata[31:29], 0);
          if (m_tlast != e.run_last) report_mismatch("tlast", m_tlast, e.run_last);
          if (e.frame_done) frames_seen++;
        end
        results_seen++;
      end
      // long hold-off so the block fills up and backs up its input
      if (want_hold != 0 && hold_count < HOLD_CYCLES)
        m_tready <= 1'b0;
      else
        m_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:   width_reg = val[10:0];
      REG_HEIGHT:  height_reg = val[10:0];
      REG_KTOP:    kern_reg[0] = val;
      REG_KMID:    kern_reg[1] = val;
      REG_KBOT:    kern_reg[2] = val;
      REG_DIVISOR: divisor_reg = val[7:0];
      default: ;
    endcase
  endtask

  // wait until every pixel is in and every result out, then let it settle
  task automatic drain();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel(int mode);
    case (mode)
      0: return 8'd0;
      1: return 8'd255;
      default: return ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                               : 8'($urandom());
    endcase
  endfunction

  task automatic queue_pixels(int count, int mode);
    logic [7:0] p;
    for (int i = 0; i < count; i++) begin
      p = pick_pixel(mode);
      advance_filter(p);
      pending_pixels.push_back(p);
    end
  endtask

  // one full frame under a fresh setting; called at a frame boundary only
  task automatic run_frame(int w, int h, logic [17:0] kt, logic [17:0] km,
                           logic [17:0] kb, logic [7:0] dv, int mode);
    drain();
    write_reg(REG_WIDTH, 18'(w));
    write_reg(REG_HEIGHT, 18'(h));
    write_reg(REG_KTOP, kt);
    write_reg(REG_KMID, km);
    write_reg(REG_KBOT, kb);
    write_reg(REG_DIVISOR, 18'(dv));
    queue_pixels(clamp_dim(11'(w), MAXW) * clamp_dim(11'(h), MAXH), mode);
  endtask

  function automatic logic [17:0] pick_kernel();
    case ($urandom_range(5))
      0: return 18'h01041;                    // all ones
      1: return 18'h01081;                    // 1 2 1
      2: return 18'h00FC0;                    // 0 -1 0
      3: return 18'h3FFFF;                    // all -1
      default: return 18'($urandom());
    endcase
  endfunction

  localparam logic [17:0] KERN_MAXPOS = 18'h1F7DF;  // +31 in every tap
  localparam logic [17:0] KERN_MAXNEG = 18'h20820;  // -32 in every tap

  initial begin
    int w;
    int h;
    int k;
    width_reg = 11'd640;
    height_reg = 11'd480;
    kern_reg[0] = '0;
    kern_reg[1] = 18'd64;
    kern_reg[2] = '0;
    divisor_reg = 8'd1;
    for (int i = 0; i < MAXW; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
    col_cnt = 0;
    row_cnt = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturation both ways, zero and max divisor, degenerate sizes
    run_frame(3, 3, KERN_MAXPOS, KERN_MAXPOS, KERN_MAXPOS, 8'd0, 1);
    run_frame(3, 3, KERN_MAXNEG, KERN_MAXNEG, KERN_MAXNEG, 8'd255, 1);
    run_frame(0, 0, 18'h0, 18'd64, 18'h0, 8'd1, 0);
    run_frame(1, 1, KERN_MAXNEG, KERN_MAXPOS, 18'h0, 8'd1, 1);
    run_frame(2, 1, 18'h01041, 18'h01041, 18'h01041, 8'd9, 2);

    // oversized geometry clamps; the frame is cut short by a shrink
    drain();
    write_reg(REG_WIDTH, 18'd2047);
    write_reg(REG_HEIGHT, 18'd1);
    queue_pixels(20, 2);
    drain();
    write_reg(REG_WIDTH, 18'd5);
    while (col_cnt != 0 || row_cnt != 0) queue_pixels(1, 2);
    drain();
    write_reg(REG_WIDTH, 18'd1);
    write_reg(REG_HEIGHT, 18'd2047);
    queue_pixels(20, 2);
    drain();
    write_reg(REG_HEIGHT, 18'd3);
    while (col_cnt != 0 || row_cnt != 0) queue_pixels(1, 2);

    // pressure: hold the output off while a busy frame streams in
    drain();
    want_hold = 1;
    run_frame(8, 6, pick_kernel(), pick_kernel(), pick_kernel(), 8'($urandom()), 2);

    // random frames, occasionally reshaped mid-frame
    for (k = 0; k < 16; k++) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3, 8);
      h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
      if ($urandom_range(5) == 0 && w > 3 && h > 3) begin
        drain();
        write_reg(REG_WIDTH, 18'(w));
        write_reg(REG_HEIGHT, 18'(h));
        write_reg(REG_KTOP, pick_kernel());
        write_reg(REG_KMID, pick_kernel());
        write_reg(REG_KBOT, pick_kernel());
        write_reg(REG_DIVISOR, 18'($urandom_range(255)));
        queue_pixels($urandom_range(w + 1, w * h - 1), 2);
        drain();
        // shrinking only, so every line store entry read was written
        if ($urandom_range(1))
          write_reg(REG_WIDTH, 18'($urandom_range(w - 1)));
        else
          write_reg(REG_HEIGHT, 18'($urandom_range(h - 1)));
        while (col_cnt != 0 || row_cnt != 0) queue_pixels(1, 2);
      end else begin
        run_frame(w, h, pick_kernel(), pick_kernel(), pick_kernel(),
                  8'($urandom_range(255)), 2);
      end
    end

    drain();
    $display("covered %0d pixels, %0d results, %0d frames", pixels_sent, results_seen,
             frames_seen);
    $display("saturation, clamped sizes, mid-frame reshapes and backpressure exercised");
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
rtl/c3f_pkg.sv
rtl/c3f_ram.sv
rtl/c3f_front.sv
rtl/c3f_back.sv
rtl/conv3x3_image_filter.sv
tb/tb_top.sv
